[rtl/b2da_pkg.sv]
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

  // Width of the value field on the input stream.
  localparam int ValueW = 32;

  // Default width of the converted value.
  localparam int DefValueBits = 32;

  // Width of one ASCII digit character on the output stream.
  localparam int DigitCharW = 6;

  // Output stream data width: the digit character padded to a whole byte.
  localparam int OutDataW = 8;

  // ASCII code of the character '0'.
  localparam logic [DigitCharW-1:0] AsciiZero = DigitCharW'(48);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // Capture a new value and clear the digit register.
    logic shift_bin;    // One adjust-and-shift step of the conversion.
    logic shift_digit;  // Move the next digit into the top position.
  } b2da_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_shift;   // The current conversion step is the final one.
    logic top_zero;     // The digit in the top position is zero.
    logic last_digit;   // The top position holds the least significant digit.
  } b2da_status_t;

endpackage

[rtl/binary_to_decimal_ascii.sv]
// Binary to decimal ASCII converter top level: controller plus datapath.
//
// Each request on the input stream carries one unsigned value; the block answers with its
// decimal digits as ASCII characters, most significant first, leading zeros dropped, and
// tlast on the final character (zero gives the single character '0'). One value is handled
// at a time: the input is ready only while the block is idle. After a value is taken the
// shift-and-add-3 loop runs over all VALUE_BITS bits, one bit per cycle, then the leading
// zero digits are skipped, then each digit is presented until it is accepted. Only the
// low VALUE_BITS bits of the value are converted.
module binary_to_decimal_ascii import b2da_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ValueW-1:0]   s_axis_tdata_i,   // [31:0] value
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [5:0] digit_char, [7:6] zero
  output logic                m_axis_tlast_o    // last_digit
);

  b2da_cmd_t             cmd;
  b2da_status_t          status;
  logic [DigitCharW-1:0] digit_char;

  b2da_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  b2da_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (s_axis_tdata_i),
    .digit_char_o (digit_char),
    .last_digit_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OutDataW-DigitCharW){1'b0}}, digit_char};

endmodule

[rtl/b2da_datapath.sv]
// Datapath of the converter: shift-and-add-3 registers, step counters and digit output.
module b2da_datapath import b2da_pkg::*; #(
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b2da_cmd_t             cmd_i,
  output b2da_status_t          status_o,
  input  logic [ValueW-1:0]     value_i,
  output logic [DigitCharW-1:0] digit_char_o,
  output logic                  last_digit_o
);

  localparam int NumDigits = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BcdW      = NumDigits * 4;
  localparam int BitCntW   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DigCntW   = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  logic [VALUE_BITS-1:0] value_masked;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d, bcd_adj;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic [3:0]            top_digit;

  // Keep only the low VALUE_BITS bits of the input value.
  if (VALUE_BITS <= ValueW) begin : g_trunc
    assign value_masked = value_i[VALUE_BITS-1:0];
  end else begin : g_extend
    assign value_masked = {{(VALUE_BITS-ValueW){1'b0}}, value_i};
  end

  // Add 3 to every digit that is 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Next values of the payload registers.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (cmd_i.load) begin
      bin_d = value_masked;
      bcd_d = '0;
    end else if (cmd_i.shift_bin) begin
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
    end else if (cmd_i.shift_digit) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
    end
  end

  // Next values of the step counters.
  always_comb begin
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    if (cmd_i.load) begin
      bit_cnt_d = '0;
      dig_cnt_d = '0;
    end else begin
      if (cmd_i.shift_bin) begin
        bit_cnt_d = bit_cnt_q + 1'b1;
      end
      if (cmd_i.shift_digit) begin
        dig_cnt_d = dig_cnt_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // Counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  // Status and the digit in the top position.
  assign top_digit           = bcd_q[BcdW-1 -: 4];
  assign status_o.last_shift = (bit_cnt_q == BitCntW'(VALUE_BITS - 1));
  assign status_o.top_zero   = (top_digit == 4'd0);
  assign status_o.last_digit = (dig_cnt_q == DigCntW'(NumDigits - 1));

  assign digit_char_o = AsciiZero + {{(DigitCharW-4){1'b0}}, top_digit};
  assign last_digit_o = status_o.last_digit;

endmodule

[rtl/b2da_ctrl.sv]
// Controller state machine of the converter: load, convert, skip leading zeros, emit.
module b2da_ctrl import b2da_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output b2da_cmd_t    cmd_o,
  input  b2da_status_t status_i
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift_bin = 1'b1;
        if (status_i.last_shift) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zeros but always keep the least significant digit.
        if (status_i.top_zero && !status_i.last_digit) begin
          cmd_o.shift_digit = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last_digit) begin
            state_d = StIdle;
          end else begin
            cmd_o.shift_digit = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/b2da_checker.sv]
// Port-level assertion checker for the converter, bound to the top level.
module b2da_checker import b2da_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o
);

  // No new request is taken while a run of digits is still being sent.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while output digits are pending");

  // Every character shown is an ASCII decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o >= 8'd48) && (m_axis_tdata_o <= 8'd57))
    else $error("output character is not a decimal digit");

  // A stalled character holds its data and mark.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

  // An accepted value starts a conversion: no digit and no ready in the next cycle.
  a_conv_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !m_axis_tvalid_o && !s_axis_tready_o)
    else $error("conversion did not start after input request");

  // The end of a run returns the block to idle.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=> s_axis_tready_o)
    else $error("block not ready after the last digit");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);
